>>> hdl/hpssw_pkg.sv
// ----------------------------------------------------------------------------
// hpssw_pkg
// Shared types and constants of the hex patch scatter writer.
// ----------------------------------------------------------------------------
package hpssw_pkg;

  localparam int unsigned MaxSegmentsDef  = 64;
  localparam int unsigned OffsetDigitsDef = 8;

  // item kinds
  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_CHAR   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // parser phases
  typedef enum logic [2:0] {
    PH_LINE   = 3'd0,
    PH_OFFSET = 3'd1,
    PH_FIELD  = 3'd2,
    PH_PAIR1  = 3'd3,
    PH_PAIR2  = 3'd4,
    PH_SKIP   = 3'd5,
    PH_HALT   = 3'd6
  } phase_t;

  // top level sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_WAIT,
    ST_TEST,
    ST_OUT
  } state_t;

  localparam logic [7:0] ChNul   = 8'd0;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChVt    = 8'd11;
  localparam logic [7:0] ChFf    = 8'd12;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChSemi  = 8'h3b;

  // hex digit decode: bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

>>> hdl/hex_patch_stream_scatter_writer.sv
// ----------------------------------------------------------------------------
// hex_patch_stream_scatter_writer
// Parses hex patch text and scatters each byte through a segment table.
// ----------------------------------------------------------------------------
// A table item or a character that yields no byte is taken in the idle state
// and leaves the block ready. A byte is translated by a sequencer that walks
// the segment table through one shared subtract-and-compare unit, reading one
// entry from the base and length RAMs per step, through the lookup, wait and
// test states, and then the output state when the byte lands in a segment. A
// byte with an empty table still passes the lookup state, as it still advances
// the offset. in_tready is low during the walk and while a result waits on the
// output register.
module hex_patch_stream_scatter_writer #(
  parameter int unsigned MAX_SEGMENTS  = hpssw_pkg::MaxSegmentsDef,
  parameter int unsigned OFFSET_DIGITS = hpssw_pkg::OffsetDigitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] kind, [33:2] seg_base, [65:34] seg_length, [73:66] text_char
  input  logic [79:0] in_tdata,
  input  logic        in_tlast,      // final_char
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] write_address, [39:32] write_data
  output logic [39:0] out_tdata
);
  import hpssw_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] SegMax = CW'(MAX_SEGMENTS);

  state_t      st_r, st_nxt;
  logic [CW-1:0] cnt_r, idx_r;
  logic [31:0] rem_r, len_q, base_q, addr_r;
  logic [7:0]  data_r;
  logic [1:0]  kind;
  logic        acc, p_emit, p_adv, last_seg;
  logic [7:0]  p_data;
  logic [31:0] p_off;
  logic [32:0] diff;

  assign kind = in_tdata[1:0];
  assign in_tready = st_r == ST_IDLE;
  assign acc = in_tvalid && in_tready;
  assign out_tvalid = st_r == ST_OUT;
  assign out_tdata = {data_r, addr_r};

  hpssw_parser #(.OFFSET_DIGITS(OFFSET_DIGITS)) u_parser (
    .clk, .rst_n,
    .step(acc && kind == KIND_CHAR),
    .text_char(in_tdata[73:66]), .final_char(in_tlast),
    .emit(p_emit), .emit_data(p_data), .emit_offset(p_off),
    .advance(p_adv)
  );

  logic app;
  assign app = acc && kind == KIND_APPEND && cnt_r < SegMax;

  hpssw_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_base (
    .clk, .wr_en(app), .wr_addr(cnt_r), .wr_data(in_tdata[33:2]),
    .rd_addr(idx_r), .rd_data(base_q));
  hpssw_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_len (
    .clk, .wr_en(app), .wr_addr(cnt_r), .wr_data(in_tdata[65:34]),
    .rd_addr(idx_r), .rd_data(len_q));

  // shared subtract/compare: remainder minus current segment length
  assign diff = {1'b0, rem_r} - {1'b0, len_q};
  assign last_seg = idx_r + 1'b1 >= cnt_r;
  assign p_adv = st_r == ST_LOOKUP;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:
        if (acc && kind == KIND_CHAR && p_emit) st_nxt = ST_LOOKUP;
      // every byte advances the offset; an empty table writes nothing
      ST_LOOKUP: st_nxt = (cnt_r == '0) ? ST_IDLE : ST_WAIT;
      ST_WAIT:   st_nxt = ST_TEST;
      ST_TEST:
        if (!diff[32] && !last_seg) st_nxt = ST_WAIT;
        else if (diff[32]) st_nxt = ST_OUT;
        else st_nxt = ST_IDLE;
      ST_OUT: if (out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (acc && kind == KIND_CLEAR) cnt_r <= '0;
      else if (app) cnt_r <= cnt_r + 1'b1;
    end
    case (st_r)
      ST_IDLE: begin
        idx_r  <= '0;
        data_r <= p_data;
      end
      ST_LOOKUP: rem_r <= p_off;
      ST_TEST: begin
        if (!diff[32] && !last_seg) begin
          rem_r <= diff[31:0];
          idx_r <= idx_r + 1'b1;
        end
        addr_r <= rem_r + base_q;
      end
      default: ;
    endcase
  end
endmodule

>>> hdl/hpssw_ram.sv
// ----------------------------------------------------------------------------
// hpssw_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module hpssw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH+1)-1:0]       wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [$clog2(DEPTH+1)-1:0]       rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr[AW-1:0]] <= wr_data;
    rd_data_r <= mem[rd_addr[AW-1:0]];
  end

  assign rd_data = rd_data_r;
endmodule

>>> hdl/hpssw_parser.sv
// ----------------------------------------------------------------------------
// hpssw_parser
// Character parser: phase, offset accumulation and hex pair assembly.
// Updates its state on the step strobe, its offset also on the advance strobe,
// and flags bytes that need translating.
module hpssw_parser #(
  parameter int unsigned OFFSET_DIGITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  text_char,
  input  logic        final_char,
  output logic        emit,
  output logic [7:0]  emit_data,
  output logic [31:0] emit_offset,
  input  logic        advance
);
  import hpssw_pkg::*;

  localparam int unsigned DW = $clog2(OFFSET_DIGITS + 1);
  localparam logic [DW-1:0] DigMax = DW'(OFFSET_DIGITS);

  phase_t      phase_r, phase_nxt;
  logic [31:0] off_r, off_nxt;
  logic [DW-1:0] dig_r, dig_nxt;
  logic [4:0]  hn_r, hn_nxt;
  logic [4:0]  h;
  logic        blank;

  assign h = hex_decode(text_char);
  assign blank = text_char == ChSpace || text_char == ChTab ||
                 text_char == ChVt || text_char == ChFf;
  assign emit_offset = off_r;

  // next state of the parser for the current character
  always_comb begin
    phase_nxt = phase_r;
    off_nxt   = off_r;
    dig_nxt   = dig_r;
    hn_nxt    = hn_r;
    emit      = 1'b0;
    emit_data = 8'd0;
    case (phase_r)
      PH_OFFSET: begin
        if (text_char == ChSpace) phase_nxt = PH_FIELD;
        else if (text_char == ChLf) phase_nxt = PH_LINE;
        else if (text_char == ChNul) phase_nxt = PH_HALT;
        else if (dig_r < DigMax && h[4]) begin
          off_nxt = {off_r[27:0], h[3:0]};
          dig_nxt = dig_r + 1'b1;
        end else dig_nxt = DigMax;
      end
      PH_FIELD: begin
        if (text_char == ChSpace) phase_nxt = PH_PAIR1;
        else if (text_char == ChLf) phase_nxt = PH_LINE;
        else if (text_char == ChNul) phase_nxt = PH_HALT;
      end
      PH_PAIR1: begin
        if (text_char == ChLf) phase_nxt = PH_LINE;
        else if (text_char == ChCr) phase_nxt = PH_SKIP;
        else if (text_char == ChNul) phase_nxt = PH_HALT;
        else begin
          if (h[4]) hn_nxt = h;
          else if (blank) hn_nxt = 5'd1;
          else hn_nxt = 5'd0;
          phase_nxt = PH_PAIR2;
          if (final_char) begin
            emit = 1'b1;
            emit_data = h[4] ? {4'd0, h[3:0]} : 8'd0;
          end
        end
      end
      PH_PAIR2: begin
        emit = 1'b1;
        if (hn_r[4]) emit_data = h[4] ? {hn_r[3:0], h[3:0]} : {4'd0, hn_r[3:0]};
        else if (hn_r == 5'd1) emit_data = h[4] ? {4'd0, h[3:0]} : 8'd0;
        else emit_data = 8'd0;
        phase_nxt = PH_PAIR1;
      end
      PH_SKIP: begin
        if (text_char == ChLf) phase_nxt = PH_LINE;
        else if (text_char == ChNul) phase_nxt = PH_HALT;
      end
      PH_HALT: ;
      default: begin
        if (text_char == ChNul) phase_nxt = PH_HALT;
        else if (text_char == ChLf) phase_nxt = PH_LINE;
        else if (text_char == ChHash || text_char == ChSemi ||
                 text_char == ChCr || text_char == ChSpace) phase_nxt = PH_SKIP;
        else begin
          phase_nxt = PH_OFFSET;
          if (h[4]) begin
            off_nxt = {28'd0, h[3:0]};
            dig_nxt = DW'(1);
          end else begin
            off_nxt = 32'd0;
            dig_nxt = DigMax;
          end
        end
      end
    endcase
    if (final_char) begin
      phase_nxt = PH_LINE;
      dig_nxt   = '0;
      hn_nxt    = 5'd0;
    end
  end

  // state registers; the offset steps once per translated byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LINE;
      off_r   <= 32'd0;
      dig_r   <= '0;
      hn_r    <= 5'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      dig_r   <= dig_nxt;
      hn_r    <= hn_nxt;
    end else if (advance) begin
      off_r <= off_r + 32'd1;
    end
  end
endmodule
